@@ hw/rtl/pti_pkg.sv @@
`default_nettype none

package pti_pkg;

  // Input word kinds carried in the slave tuser
  typedef enum logic [1:0] {
    KindJoystick = 2'd0,
    KindButton   = 2'd1,
    KindError    = 2'd2
  } kind_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgPanLimit  = 2'd0,
    CfgTiltLimit = 2'd1
  } cfg_idx_e;

  localparam int unsigned LimitWidth       = 12;
  localparam int unsigned AngleWidth       = 16;
  localparam int unsigned SumWidth         = AngleWidth + 2;
  localparam int unsigned InDataWidth      = 56;
  localparam int unsigned InUserWidth      = 3;
  localparam int unsigned OutDataWidth     = 32;
  localparam int unsigned OutUserWidth     = 2;
  localparam int unsigned DefaultErrorDivisor = 24;

  localparam logic [LimitWidth-1:0] PanLimitReset  = 12'd1799;
  localparam logic [LimitWidth-1:0] TiltLimitReset = 12'd899;

  // Clamp a widened angle to 0..lim
  function automatic logic signed [AngleWidth-1:0] clamp_limit(
    input logic signed [SumWidth-1:0] v,
    input logic [LimitWidth-1:0]      lim
  );
    logic signed [SumWidth-1:0] lim_s;
    lim_s = $signed({{(SumWidth-LimitWidth){1'b0}}, lim});
    if (v < 0) begin
      clamp_limit = '0;
    end else if (v > lim_s) begin
      clamp_limit = lim_s[AngleWidth-1:0];
    end else begin
      clamp_limit = v[AngleWidth-1:0];
    end
  endfunction

  // Saturate a widened angle to the 16-bit signed range
  function automatic logic signed [AngleWidth-1:0] saturate_angle(
    input logic signed [SumWidth-1:0] v
  );
    logic signed [SumWidth-1:0] hi;
    logic signed [SumWidth-1:0] lo;
    hi = SumWidth'(32767);
    lo = -SumWidth'(32768);
    if (v > hi) begin
      saturate_angle = hi[AngleWidth-1:0];
    end else if (v < lo) begin
      saturate_angle = lo[AngleWidth-1:0];
    end else begin
      saturate_angle = v[AngleWidth-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pan_tilt_angle_integrator.sv @@
`default_nettype none

// Channel  | dir | handshake                    | payload
// ---------+-----+------------------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata stick_x,stick_y,button_bits,err_x,err_y
//          |     |                              | tuser kind,full_packet
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata pan_angle,tilt_angle
//          |     |                              | tuser auto_mode,led_toggle
// cfg      | in  | cfg_we_i (no wait)           | cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while m_axis is ready. A word's result is presented on
// m_axis once the input register has captured it and the angle/mode registers, which
// double as the result register, have loaded it.
// The critical path is one 17x25 reciprocal multiply followed by an add and a clamp.
// Reset clears both angles to zero, selects manual mode and loads the default limits.
// A stall on m_axis holds the result; the input register still takes one more word,
// then s_axis_tready drops until the result is taken.

module pan_tilt_angle_integrator #(
  parameter int unsigned ERROR_DIVISOR = pti_pkg::DefaultErrorDivisor
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // slave stream
  input  wire logic                               s_axis_tvalid,
  output      logic                               s_axis_tready,
  // [7:0] stick_x, [15:8] stick_y, [17:16] button_bits, [33:18] err_x,
  // [49:34] err_y, [55:50] zero
  input  wire logic [pti_pkg::InDataWidth-1:0]    s_axis_tdata,
  // [1:0] kind, [2] full_packet
  input  wire logic [pti_pkg::InUserWidth-1:0]    s_axis_tuser,
  // master stream
  output      logic                               m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] pan_angle, [31:16] tilt_angle
  output      logic [pti_pkg::OutDataWidth-1:0]   m_axis_tdata,
  // [0] auto_mode, [1] led_toggle
  output      logic [pti_pkg::OutUserWidth-1:0]   m_axis_tuser,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [1:0]                         cfg_idx_i,
  input  wire logic [pti_pkg::LimitWidth-1:0]     cfg_wdata_i
);

  localparam int unsigned AW = pti_pkg::AngleWidth;
  localparam int unsigned SW = pti_pkg::SumWidth;
  localparam int unsigned LW = pti_pkg::LimitWidth;

  // Error divide: floor(n*Recip >> RecipShift) equals floor(n/ERROR_DIVISOR) exactly
  // for n below 2^16 because RecipShift covers 16 bits plus up to 8 bits of divisor.
  localparam int unsigned MagWidth   = AW + 1;
  localparam int unsigned RecipShift = 24;
  localparam int unsigned RecipWidth = RecipShift + 1;
  localparam int unsigned ProdWidth  = MagWidth + RecipWidth;
  localparam logic [RecipWidth-1:0] Recip =
    RecipWidth'(((64'd1 << RecipShift) + 64'(ERROR_DIVISOR) - 64'd1) / 64'(ERROR_DIVISOR));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [LW-1:0] pan_limit_q, tilt_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_limit_q  <= pti_pkg::PanLimitReset;
      tilt_limit_q <= pti_pkg::TiltLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pti_pkg::CfgPanLimit:  pan_limit_q  <= cfg_wdata_i;
        pti_pkg::CfgTiltLimit: tilt_limit_q <= cfg_wdata_i;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                 in_valid_q, in_valid_d;
  logic [1:0]           in_kind_q;
  logic                 in_full_q;
  logic [7:0]           in_sx_q, in_sy_q;
  logic [1:0]           in_btn_q;
  logic signed [AW-1:0] in_ex_q, in_ey_q;

  logic s_take;   // word accepted on s_axis
  logic advance;  // result register free to load
  logic load;     // move the held word into the state/result register

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign load          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_take) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_kind_q <= s_axis_tuser[1:0];
      in_full_q <= s_axis_tuser[2];
      in_sx_q   <= s_axis_tdata[7:0];
      in_sy_q   <= s_axis_tdata[15:8];
      in_btn_q  <= s_axis_tdata[17:16];
      in_ex_q   <= $signed(s_axis_tdata[33:18]);
      in_ey_q   <= $signed(s_axis_tdata[49:34]);
    end
  end

  // ---------------------------------------------------------------------------
  // Angle update
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] pan_q, pan_d, tilt_q, tilt_d;
  logic                 mode_q, mode_d;
  logic                 led_q, led_d;
  logic                 out_valid_q, out_valid_d;

  // Centered stick: value minus 128 is the byte with its top bit flipped
  logic signed [7:0]    dx, dy, dx_sh, dy_sh;
  logic [2:0]           shamt;
  logic signed [SW-1:0] pan_wide, tilt_wide, pan_joy, tilt_joy;

  assign dx    = $signed({~in_sx_q[7], in_sx_q[6:0]});
  assign dy    = $signed({~in_sy_q[7], in_sy_q[6:0]});
  assign shamt = in_btn_q[1] ? 3'd2 : 3'd3;  // C pressed: finer step
  assign dx_sh = dx >>> shamt;
  assign dy_sh = dy >>> shamt;

  assign pan_wide  = SW'(pan_q);
  assign tilt_wide = SW'(tilt_q);
  assign pan_joy   = pan_wide  - SW'(dx_sh);
  assign tilt_joy  = tilt_wide + SW'(dy_sh);

  // Camera error / divisor, truncated toward zero: divide the magnitude, restore sign
  logic [MagWidth-1:0]  mag_x, mag_y, quo_x, quo_y;
  logic [ProdWidth-1:0] prod_x, prod_y;
  logic signed [SW-1:0] qs_x, qs_y, pan_err, tilt_err;

  assign mag_x  = in_ex_q[AW-1] ? MagWidth'(-SW'(in_ex_q)) : MagWidth'(in_ex_q);
  assign mag_y  = in_ey_q[AW-1] ? MagWidth'(-SW'(in_ey_q)) : MagWidth'(in_ey_q);
  assign prod_x = ProdWidth'(mag_x) * ProdWidth'(Recip);
  assign prod_y = ProdWidth'(mag_y) * ProdWidth'(Recip);
  assign quo_x  = prod_x[RecipShift +: MagWidth];
  assign quo_y  = prod_y[RecipShift +: MagWidth];
  assign qs_x   = in_ex_q[AW-1] ? -$signed(SW'(quo_x)) : $signed(SW'(quo_x));
  assign qs_y   = in_ey_q[AW-1] ? -$signed(SW'(quo_y)) : $signed(SW'(quo_y));
  assign pan_err  = pan_wide  - qs_x;
  assign tilt_err = tilt_wide + qs_y;

  always_comb begin
    pan_d  = pan_q;
    tilt_d = tilt_q;
    mode_d = mode_q;
    led_d  = 1'b0;
    case (in_kind_q)
      pti_pkg::KindJoystick: begin
        if (in_full_q) begin
          if (!in_btn_q[0]) begin  // Z pressed: go automatic
            mode_d = 1'b1;
            led_d  = 1'b1;
          end
          pan_d  = pti_pkg::clamp_limit(pan_joy, pan_limit_q);
          tilt_d = pti_pkg::clamp_limit(tilt_joy, tilt_limit_q);
        end
      end
      pti_pkg::KindButton: begin
        if (in_full_q) begin
          if (in_btn_q[0]) begin  // Z released: back to manual
            mode_d = 1'b0;
            led_d  = 1'b1;
          end
          pan_d  = pti_pkg::clamp_limit(pan_wide, pan_limit_q);
          tilt_d = pti_pkg::clamp_limit(tilt_wide, tilt_limit_q);
        end
      end
      pti_pkg::KindError: begin
        pan_d  = pti_pkg::saturate_angle(pan_err);
        tilt_d = pti_pkg::saturate_angle(tilt_err);
      end
      default: ;  // unused kind: hold state
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // The state registers are the result register: they only change on load,
  // which waits for the previous result to be taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q       <= '0;
      tilt_q      <= '0;
      mode_q      <= 1'b0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        pan_q  <= pan_d;
        tilt_q <= tilt_d;
        mode_q <= mode_d;
        led_q  <= led_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {tilt_q, pan_q};
  assign m_axis_tuser  = {led_q, mode_q};

`ifndef SYNTH
  // Mode changes only together with a mode event on the presented result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(mode_q) |-> (led_q && out_valid_q))
    else $error("mode changed without a mode event");

  // A held input word that cannot advance stays held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_ex_q) && $stable(in_kind_q)))
    else $error("input register lost a stalled word");

  // Joystick and button updates land inside the configured window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && in_full_q && (in_kind_q == pti_pkg::KindJoystick ||
                           in_kind_q == pti_pkg::KindButton))
    |-> (pan_d >= 0 && $unsigned(pan_d) <= AW'(pan_limit_q) &&
         tilt_d >= 0 && $unsigned(tilt_d) <= AW'(tilt_limit_q)))
    else $error("clamped angle outside its limit");

  // A new result appears only from a held input word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result presented without an input word");
`endif

endmodule

`default_nettype wire

@@ tb/pti_angle_checker.sv @@
module pti_angle_checker
  import pti_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  input  logic [InUserWidth-1:0]  s_axis_tuser,
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [OutDataWidth-1:0] m_axis_tdata,
  input  logic [OutUserWidth-1:0] m_axis_tuser,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [LimitWidth-1:0]   cfg_wdata_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic signed [AngleWidth-1:0] pan;
    logic signed [AngleWidth-1:0] tilt;
    logic                         auto_mode;
    logic                         led;
  } angle_result_t;

  // Shadow copy of the block's state and limits
  logic [LimitWidth-1:0] pan_lim;
  logic [LimitWidth-1:0] tilt_lim;
  int                    pan_deg;
  int                    tilt_deg;
  logic                  auto_mode;

  angle_result_t angle_expect_q[$];
  angle_result_t got;
  angle_result_t want;
  int            fail_total;
  int            result_idx;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the shadow state by one word and return the angles it leaves
  function automatic angle_result_t integrate_word(
    input logic [InDataWidth-1:0] data,
    input logic [InUserWidth-1:0] user
  );
    logic [1:0]                   kind;
    logic                         full;
    logic [7:0]                   sx;
    logic [7:0]                   sy;
    logic [1:0]                   btn;
    logic signed [AngleWidth-1:0] ex;
    logic signed [AngleWidth-1:0] ey;
    int                           shift;
    int                           divisor;
    angle_result_t                res;
    kind    = user[1:0];
    full    = user[2];
    sx      = data[7:0];
    sy      = data[15:8];
    btn     = data[17:16];
    ex      = data[33:18];
    ey      = data[49:34];
    divisor = int'(DefaultErrorDivisor);
    res.led = 1'b0;
    case (kind)
      KindJoystick: begin
        if (full) begin
          // C pressed (level 0) slows the stick down
          shift = btn[1] ? 2 : 3;
          if (!btn[0]) begin
            auto_mode = 1'b1;
            res.led   = 1'b1;
          end
          tilt_deg = clamp_int(tilt_deg + ((int'(sy) - 128) >>> shift), 0, int'(tilt_lim));
          pan_deg  = clamp_int(pan_deg - ((int'(sx) - 128) >>> shift), 0, int'(pan_lim));
        end
      end
      KindButton: begin
        if (full) begin
          if (btn[0]) begin
            auto_mode = 1'b0;
            res.led   = 1'b1;
          end
          tilt_deg = clamp_int(tilt_deg, 0, int'(tilt_lim));
          pan_deg  = clamp_int(pan_deg, 0, int'(pan_lim));
        end
      end
      KindError: begin
        // Division truncates toward zero; framing bit is not looked at
        pan_deg  = clamp_int(pan_deg - int'(ex) / divisor, -32768, 32767);
        tilt_deg = clamp_int(tilt_deg + int'(ey) / divisor, -32768, 32767);
      end
      default: ;
    endcase
    res.pan       = pan_deg[AngleWidth-1:0];
    res.tilt      = tilt_deg[AngleWidth-1:0];
    res.auto_mode = auto_mode;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_lim      = PanLimitReset;
      tilt_lim     = TiltLimitReset;
      pan_deg      = 0;
      tilt_deg     = 0;
      auto_mode    = 1'b0;
      fail_total   = 0;
      result_idx   = 0;
      angle_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPanLimit:  pan_lim  = cfg_wdata_i;
          CfgTiltLimit: tilt_lim = cfg_wdata_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.pan       = m_axis_tdata[15:0];
        got.tilt      = m_axis_tdata[31:16];
        got.auto_mode = m_axis_tuser[0];
        got.led       = m_axis_tuser[1];
        if (angle_expect_q.size() == 0) begin
          if (fail_total < ReportLimit)
            $display("result word %0d arrived with nothing outstanding", result_idx);
          fail_total++;
        end else begin
          want = angle_expect_q.pop_front();
          if (got.pan !== want.pan || got.tilt !== want.tilt ||
              got.auto_mode !== want.auto_mode || got.led !== want.led) begin
            if (fail_total < ReportLimit)
              $display("result word %0d: expected pan %0d tilt %0d auto %0b led %0b, got pan %0d tilt %0d auto %0b led %0b",
                       result_idx, want.pan, want.tilt, want.auto_mode, want.led,
                       got.pan, got.tilt, got.auto_mode, got.led);
            fail_total++;
          end
        end
        result_idx++;
      end
      if (s_axis_tvalid && s_axis_tready)
        angle_expect_q.push_back(integrate_word(s_axis_tdata, s_axis_tuser));
      pending_o    <= angle_expect_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

@@ tb/tb_pan_tilt_angle_integrator.sv @@
module tb_pan_tilt_angle_integrator;
  timeunit 1ns;
  timeprecision 1ps;
  import pti_pkg::*;

  // Codes the package leaves unnamed: the spare word kind and spare register indexes
  localparam logic [1:0] KindSpare  = 2'd3;
  localparam logic [1:0] CfgSpareLo = 2'd2;
  localparam logic [1:0] CfgSpareHi = 2'd3;

  localparam int ItemsPerPhase = 225;
  localparam int StormLen      = 30;
  localparam int HoldCycles    = 90;
  localparam int HoldSpacing   = 900;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // [7:0] stick_x, [15:8] stick_y, [17:16] button_bits, [33:18] err_x,
  // [49:34] err_y, [55:50] zero
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  // [1:0] kind, [2] full_packet
  logic [InUserWidth-1:0]  s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [15:0] pan_angle, [31:16] tilt_angle
  logic [OutDataWidth-1:0] m_axis_tdata;
  // [0] auto_mode, [1] led_toggle
  logic [OutUserWidth-1:0] m_axis_tuser;
  logic                    cfg_we_i      = 1'b0;
  logic [1:0]              cfg_idx_i     = '0;
  logic [LimitWidth-1:0]   cfg_wdata_i   = '0;

  int fail_count;
  int pending;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  pan_tilt_angle_integrator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  pti_angle_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Present one word and hold it until the block takes it. Called right after a
  // rising edge; tready is sampled with its value from before that edge.
  task automatic send_word(
    input logic [1:0]                   kind,
    input logic                         full,
    input logic [7:0]                   sx,
    input logic [7:0]                   sy,
    input logic [1:0]                   btn,
    input logic signed [AngleWidth-1:0] ex,
    input logic signed [AngleWidth-1:0] ey
  );
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, ey, ex, btn, sy, sx};
    s_axis_tuser  <= {full, kind};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid for a pause of length n (n >= 1)
  task automatic pause(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stop offering words until every outstanding result has come back, then let
  // the two pipeline stages settle before anything else happens.
  task automatic drain();
    pause(1);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write both limits plus a spare index that must be ignored; block is idle here.
  task automatic write_limits(input logic [LimitWidth-1:0] pan_lim,
                              input logic [LimitWidth-1:0] tilt_lim);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgPanLimit;
    cfg_wdata_i <= pan_lim;
    @(posedge clk_i);
    cfg_idx_i   <= CfgTiltLimit;
    cfg_wdata_i <= tilt_lim;
    @(posedge clk_i);
    cfg_idx_i   <= $urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi;
    cfg_wdata_i <= LimitWidth'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_stick();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(120, 136));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic signed [AngleWidth-1:0] pick_error();
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return 16'sd32767;
      2:       return 16'($urandom_range(0, 200) - 100);
      // land on and around multiples of the divisor
      3:       return 16'(($urandom_range(0, 40) - 20) * 24 + $urandom_range(0, 2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  // One random word; counted is low for words the block just ignores
  task automatic send_random_word(output bit counted);
    int roll;
    roll    = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < 42) begin
      send_word(KindJoystick, 1'b1, pick_stick(), pick_stick(), 2'($urandom),
                16'($urandom), 16'($urandom));
    end else if (roll < 57) begin
      send_word(KindButton, 1'b1, 8'($urandom), 8'($urandom), 2'($urandom),
                16'($urandom), 16'($urandom));
    end else if (roll < 90) begin
      send_word(KindError, 1'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                pick_error(), pick_error());
    end else begin
      // noise: broken packets and the spare kind
      counted = 1'b0;
      case ($urandom_range(0, 2))
        0: send_word(KindJoystick, 1'b0, 8'($urandom), 8'($urandom), 2'($urandom),
                     16'($urandom), 16'($urandom));
        1: send_word(KindButton, 1'b0, 8'($urandom), 8'($urandom), 2'($urandom),
                     16'($urandom), 16'($urandom));
        default: send_word(KindSpare, 1'($urandom), 8'($urandom), 8'($urandom),
                           2'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  // Push both angles hard toward a rail with a run of extreme camera errors
  task automatic error_storm();
    logic signed [AngleWidth-1:0] ex;
    logic signed [AngleWidth-1:0] ey;
    ex = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
    ey = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
    repeat (StormLen)
      send_word(KindError, 1'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), ex, ey);
  endtask

  // Bursty traffic; optionally hold off once mid-phase until everything is back
  task automatic run_traffic(input int n_items, input bit mid_drain);
    int sent;
    int burst;
    int gap;
    bit counted;
    bit drained;
    sent    = 0;
    drained = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(0, 29) == 0) begin
        error_storm();
        sent += StormLen;
      end else begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_random_word(counted);
          if (counted) sent++;
        end
      end
      if (mid_drain && !drained && sent >= n_items / 2) begin
        drained = 1'b1;
        drain();
      end else begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) pause(gap);
      end
    end
  endtask

  // Receiver: random stall patterns, with a long hold-off now and then so the
  // block fills both stages and drops s_axis_tready.
  initial begin : rx_stalls
    int mode;
    int seg_len;
    int since_hold;
    int k;
    since_hold = HoldSpacing - 300;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (since_hold >= HoldSpacing) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        since_hold = 0;
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(8, 60);
        for (k = 0; k < seg_len; k++) begin
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom);
            2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= (k % 4 != 0);
          endcase
          @(posedge clk_i);
          since_hold++;
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stick and button extremes at reset limits
    send_word(KindJoystick, 1'b1, 8'd0,   8'd255, 2'b11, 16'sd0, 16'sd0);
    send_word(KindJoystick, 1'b1, 8'd0,   8'd255, 2'b00, 16'sd0, 16'sd0);
    send_word(KindJoystick, 1'b1, 8'd255, 8'd0,   2'b10, 16'sd0, 16'sd0);
    send_word(KindJoystick, 1'b1, 8'd128, 8'd128, 2'b01, 16'sd0, 16'sd0);
    send_word(KindJoystick, 1'b1, 8'd127, 8'd129, 2'b11, 16'sd0, 16'sd0);
    // incomplete packets change nothing; full button words in between
    send_word(KindJoystick, 1'b0, 8'd0,   8'd0,   2'b00, 16'sd0, 16'sd0);
    send_word(KindButton,   1'b1, 8'd255, 8'd255, 2'b01, 16'sd0, 16'sd0);
    send_word(KindButton,   1'b1, 8'd0,   8'd0,   2'b10, 16'sd0, 16'sd0);
    send_word(KindButton,   1'b0, 8'd0,   8'd0,   2'b11, 16'sd0, 16'sd0);
    // camera errors: framing bit ignored, truncation around the divisor
    send_word(KindError, 1'b0, 8'd0, 8'd0, 2'b00, -16'sd32768, 16'sd32767);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd32767, -16'sd32768);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd23, -16'sd23);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd24, -16'sd24);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, -16'sd25, 16'sd25);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, -16'sd1, 16'sd47);
    send_word(KindSpare, 1'b1, 8'd255, 8'd0, 2'b00, 16'sd100, 16'sd100);
    // lift pan and tilt beyond the limits, then let a joystick word clamp them
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, -16'sd32768, 16'sd32767);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, -16'sd32768, 16'sd32767);
    send_word(KindJoystick, 1'b1, 8'd128, 8'd128, 2'b11, 16'sd0, 16'sd0);
    // drive both negative, then a button word clamps to zero
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd32767, -16'sd32768);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd32767, -16'sd32768);
    send_word(KindButton, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd0, 16'sd0);
    send_word(KindError, 1'b1, 8'd0, 8'd0, 2'b00, 16'sd32767, -16'sd32768);
    send_word(KindJoystick, 1'b1, 8'd255, 8'd255, 2'b01, 16'sd0, 16'sd0);

    // Random phases, each under its own limit setting
    run_traffic(ItemsPerPhase, 1'b0);
    drain();
    write_limits('0, '0);
    run_traffic(ItemsPerPhase, 1'b0);
    drain();
    write_limits('1, '1);
    run_traffic(ItemsPerPhase, 1'b1);
    drain();
    write_limits(LimitWidth'($urandom), LimitWidth'($urandom));
    run_traffic(ItemsPerPhase, 1'b0);
    drain();
    write_limits('1, '0);
    run_traffic(ItemsPerPhase, 1'b0);
    drain();
    write_limits(LimitWidth'($urandom_range(0, 40)), LimitWidth'($urandom_range(0, 40)));
    run_traffic(ItemsPerPhase, 1'b1);
    drain();
    write_limits(PanLimitReset, TiltLimitReset);
    run_traffic(ItemsPerPhase, 1'b0);

    // Wind down: everything outstanding must come back
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hang guard, far above the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
